@@ sv/morse_character_keyer_unit_assert.svh @@
// Assertion macros shared by the keyer modules.
`ifndef MORSE_CHARACTER_KEYER_UNIT_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MCK_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyer assertion failed");
`define MCK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyer assertion failed");
`else
`define MCK_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MCK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ sv/mck_pkg.sv @@
package mck_pkg;

  localparam int MaxSymbolsDefault = 6;
  localparam int QueueDepthDefault = 2;

  localparam int PatW = 8;
  localparam int LenW = 4;
  localparam int UnitW = 10;
  localparam int FreqW = 15;
  localparam int DurW = 12;
  localparam int DataW = 15;

  localparam logic [UnitW-1:0] UnitMsReset = 10'd100;
  localparam logic [FreqW-1:0] ToneFreqReset = 15'd500;

  localparam logic RegUnitMs = 1'b0;
  localparam logic RegToneFreq = 1'b1;

  typedef enum logic [1:0] {
    KindDit  = 2'd0,
    KindDah  = 2'd1,
    KindEgap = 2'd2,
    KindLgap = 2'd3
  } mck_kind_t;

  // Pattern is written in sending order: the first element is bit len-1, a one is a dah.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } mck_code_t;

  typedef struct packed {
    logic [LenW-1:0] cnt;
    logic [PatW-1:0] pat;
    logic            eow;
  } mck_entry_t;

  function automatic mck_code_t mck_code(input int n, input logic [PatW-1:0] p);
    mck_code_t r;
    r.len = LenW'(n);
    r.pat = p;
    return r;
  endfunction

  function automatic mck_code_t mck_lookup(input logic [7:0] c);
    logic [7:0] low;
    mck_code_t  r;
    low = c | 8'h20;
    r = mck_code(0, 8'h00);
    if (low >= "a" && low <= "z") begin
      case (low)
        "a": r = mck_code(2, 8'b01);
        "b": r = mck_code(4, 8'b1000);
        "c": r = mck_code(4, 8'b1010);
        "d": r = mck_code(3, 8'b100);
        "e": r = mck_code(1, 8'b0);
        "f": r = mck_code(4, 8'b0010);
        "g": r = mck_code(3, 8'b110);
        "h": r = mck_code(4, 8'b0000);
        "i": r = mck_code(2, 8'b00);
        "j": r = mck_code(4, 8'b0111);
        "k": r = mck_code(3, 8'b101);
        "l": r = mck_code(4, 8'b0100);
        "m": r = mck_code(2, 8'b11);
        "n": r = mck_code(2, 8'b10);
        "o": r = mck_code(3, 8'b111);
        "p": r = mck_code(4, 8'b0110);
        "q": r = mck_code(4, 8'b1101);
        "r": r = mck_code(3, 8'b010);
        "s": r = mck_code(3, 8'b000);
        "t": r = mck_code(1, 8'b1);
        "u": r = mck_code(3, 8'b001);
        "v": r = mck_code(4, 8'b0001);
        "w": r = mck_code(3, 8'b011);
        "x": r = mck_code(4, 8'b1001);
        "y": r = mck_code(4, 8'b1011);
        "z": r = mck_code(4, 8'b1100);
        default: r = mck_code(0, 8'h00);
      endcase
    end else begin
      case (c)
        "0": r = mck_code(5, 8'b11111);
        "1": r = mck_code(5, 8'b01111);
        "2": r = mck_code(5, 8'b00111);
        "3": r = mck_code(5, 8'b00011);
        "4": r = mck_code(5, 8'b00001);
        "5": r = mck_code(5, 8'b00000);
        "6": r = mck_code(5, 8'b10000);
        "7": r = mck_code(5, 8'b11000);
        "8": r = mck_code(5, 8'b11100);
        "9": r = mck_code(5, 8'b11110);
        "&": r = mck_code(5, 8'b01000);
        "'": r = mck_code(6, 8'b011110);
        "@": r = mck_code(6, 8'b011010);
        ")": r = mck_code(6, 8'b101101);
        "(": r = mck_code(5, 8'b10110);
        ":": r = mck_code(6, 8'b111000);
        ",": r = mck_code(6, 8'b110011);
        "=": r = mck_code(5, 8'b10001);
        "!": r = mck_code(6, 8'b101011);
        ".": r = mck_code(6, 8'b010101);
        "-": r = mck_code(6, 8'b100001);
        "+": r = mck_code(5, 8'b01010);
        "\"": r = mck_code(6, 8'b010010);
        "?": r = mck_code(6, 8'b001100);
        "/": r = mck_code(5, 8'b10010);
        default: r = mck_code(0, 8'h00);
      endcase
    end
    return r;
  endfunction

endpackage

@@ sv/mck_front.sv @@
module mck_front
  import mck_pkg::*;
#(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault
) (
  input  logic [7:0] char_code,
  input  logic       end_of_word,
  output mck_entry_t entry
);

  mck_code_t       code;
  logic [LenW-1:0] cut;

  // Patterns longer than the symbol limit keep only their leading elements.
  always_comb begin
    code = mck_lookup(char_code);
    cut = (code.len > LenW'(MAX_SYMBOLS)) ? LenW'(MAX_SYMBOLS) : code.len;
    entry.cnt = cut;
    entry.pat = code.pat >> (code.len - cut);
    entry.eow = end_of_word;
  end

endmodule

@@ sv/mck_queue.sv @@
`include "morse_character_keyer_unit_assert.svh"

module mck_queue
  import mck_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mck_entry_t wr_entry,
  output logic       full,
  input  logic       pop,
  output mck_entry_t rd_entry,
  output logic       empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mck_entry_t      mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MCK_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CntW'(DEPTH))
  `MCK_ASSERT_NEXT(a_count_up, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)
  `MCK_ASSERT_NEXT(a_count_down, clk, rst, do_pop && !do_push, count == $past(count) - 1'b1)

endmodule

@@ sv/mck_back.sv @@
`include "morse_character_keyer_unit_assert.svh"

module mck_back
  import mck_pkg::*;
#(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [UnitW-1:0] unit_ms,
  input  logic [FreqW-1:0] tone_freq_hz,
  input  mck_entry_t       q_entry,
  input  logic             q_empty,
  output logic             q_pop,
  output logic [1:0]       element_kind,
  output logic             tone_on,
  output logic [FreqW-1:0] tone_freq,
  output logic [DurW-1:0]  duration_ms,
  output logic             last_segment,
  output logic             empty,
  input  logic             pop
);

  localparam int StepW = $clog2(2 * MAX_SYMBOLS);
  localparam int TotW = StepW + 1;

  mck_entry_t       cur;
  logic             active;
  logic [StepW-1:0] step;
  logic             out_valid;
  mck_kind_t        kind;

  logic [TotW-1:0]  total;
  logic [TotW-1:0]  elems;
  logic [LenW-1:0]  idx;
  logic             emit;
  logic             is_last;
  logic [DurW-1:0]  one;
  logic [DurW-1:0]  three;
  mck_kind_t        kind_next;

  assign one = DurW'(unit_ms);
  assign three = DurW'({unit_ms, 1'b0}) + DurW'(unit_ms);

  // Elements and the gaps between them alternate, the letter gap closing the item unless end_of_word is set.
  always_comb begin
    elems = (cur.cnt != '0) ? TotW'({cur.cnt, 1'b0}) - TotW'(1) : '0;
    total = elems + TotW'(!cur.eow);
    idx = cur.cnt - LenW'(1) - LenW'(step >> 1);
    is_last = (TotW'(step) + TotW'(1) == total);
    if (TotW'(step) >= elems) begin
      kind_next = KindLgap;
    end else if (step[0]) begin
      kind_next = KindEgap;
    end else if (cur.pat[idx[$clog2(PatW)-1:0]]) begin
      kind_next = KindDah;
    end else begin
      kind_next = KindDit;
    end
  end

  assign q_pop = !active && !q_empty;
  assign emit = active && (!out_valid || pop);
  assign empty = !out_valid;
  assign element_kind = kind;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
    if (emit) begin
      kind <= kind_next;
      last_segment <= is_last;
      case (kind_next)
        KindDit: begin
          tone_on <= 1'b1;
          tone_freq <= tone_freq_hz;
          duration_ms <= one;
        end
        KindDah: begin
          tone_on <= 1'b1;
          tone_freq <= tone_freq_hz;
          duration_ms <= three;
        end
        KindEgap: begin
          tone_on <= 1'b0;
          tone_freq <= '0;
          duration_ms <= one;
        end
        default: begin
          tone_on <= 1'b0;
          tone_freq <= '0;
          duration_ms <= three;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= (q_entry.cnt != '0) || !q_entry.eow;
        step <= '0;
      end else if (emit) begin
        step <= step + 1'b1;
        if (is_last) begin
          active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MCK_ASSERT_SAME(a_step_range, clk, rst, active, TotW'(step) < total)
  `MCK_ASSERT_NEXT(a_last_ends, clk, rst, emit && is_last, !active)
  `MCK_ASSERT_NEXT(a_emit_shows, clk, rst, emit, out_valid)

endmodule

@@ sv/morse_character_keyer_unit.sv @@
// A character is taken when the queue has room; it passes through the queue and is loaded
// into the segment sequencer before its first segment is registered at the output, then
// one segment per cycle within a character while pop keeps up. A character of n >= 1 Morse
// elements gives 2*n segments with its letter gap (at most 12 by default), one fewer with
// end_of_word, and one or none for an unknown one; each is loaded once the previous is sent.
// Reset is synchronous: the queue and the output empty, unit_ms returns to 100 and tone_freq_hz to 500.
module morse_character_keyer_unit
  import mck_pkg::*;
#(
  parameter int MAX_SYMBOLS = MaxSymbolsDefault,
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [DataW-1:0] wr_data,
  input  logic [7:0]       char_code,
  input  logic             end_of_word,
  input  logic             push,
  output logic             full,
  output logic [1:0]       element_kind,
  output logic             tone_on,
  output logic [FreqW-1:0] tone_freq,
  output logic [DurW-1:0]  duration_ms,
  output logic             last_segment,
  output logic             empty,
  input  logic             pop
);

  logic [UnitW-1:0] unit_ms;
  logic [FreqW-1:0] tone_freq_hz;
  mck_entry_t       f_entry;
  mck_entry_t       q_entry;
  logic             q_empty;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ms <= UnitMsReset;
      tone_freq_hz <= ToneFreqReset;
    end else if (wr_en) begin
      case (wr_index)
        RegUnitMs: unit_ms <= wr_data[UnitW-1:0];
        RegToneFreq: tone_freq_hz <= wr_data[FreqW-1:0];
        default: ;
      endcase
    end
  end

  mck_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .char_code  (char_code),
    .end_of_word(end_of_word),
    .entry      (f_entry)
  );

  mck_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_entry(f_entry),
    .full    (full),
    .pop     (q_pop),
    .rd_entry(q_entry),
    .empty   (q_empty)
  );

  mck_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .unit_ms     (unit_ms),
    .tone_freq_hz(tone_freq_hz),
    .q_entry     (q_entry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .element_kind(element_kind),
    .tone_on     (tone_on),
    .tone_freq   (tone_freq),
    .duration_ms (duration_ms),
    .last_segment(last_segment),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
